[rtl/core/plgc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plgc_pkg
// Shared types and constants of the piecewise-linear gain calibration core.
// ----------------------------------------------------------------------------
package plgc_pkg;

    localparam int MAG_W    = 32;   // table magnitude, unsigned Q15.16
    localparam int FAC_W    = 24;   // gain factor, signed Q7.16
    localparam int SAMPLE_W = 32;   // acceleration, signed Q15.16
    localparam int QUO_W    = 25;   // interpolation quotient magnitude
    localparam int NUM_W    = 55;   // interpolation numerator magnitude
    localparam int GAIN_W   = 26;   // one plus factor
    localparam int PROD_W   = SAMPLE_W + GAIN_W;
    localparam int NREG     = 6;    // zero offset registers
    localparam int CFG_IDX_W = 3;

    localparam logic [16:0] GAIN_ONE = 17'd65536;
    localparam logic [15:0] ROUND_HALF = 16'd32768;

    localparam logic [1:0] OP_APPLY  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    typedef struct packed {
        logic [MAG_W-1:0]        mag;
        logic signed [FAC_W-1:0] fac;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_REMOVE = 2'd1,
        CELL_INSERT = 2'd2
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
        entry_t     key;
    } cell_ctrl_t;

endpackage

[rtl/core/plgc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plgc_cell
// One slot of every calibration table; shifts with its neighbors on insert
// and removal, and flags where a key falls against its stored magnitude.
// ----------------------------------------------------------------------------
module plgc_cell #(
    parameter int CELL   = 0,
    parameter int NTAB   = 6,
    parameter int POINTS = 8,
    parameter int TW     = $clog2(NTAB),
    parameter int CW     = $clog2(POINTS + 1)
) (
    input  logic                 clk,
    input  plgc_pkg::cell_ctrl_t ctrl,
    input  logic [TW-1:0]        tab,
    input  logic [CW-1:0]        nval,
    input  logic [CW-1:0]        lim,
    input  plgc_pkg::entry_t     left_entry,
    input  plgc_pkg::entry_t     right_entry,
    input  logic                 left_lt,
    input  logic                 left_ge,
    output plgc_pkg::entry_t     entry,
    output logic                 lt,
    output logic                 ge,
    output logic                 upper
);

    plgc_pkg::entry_t row_mem [NTAB];
    logic             below;
    logic             less;

    assign entry = row_mem[tab];
    assign below = CW'(CELL) < nval;
    // ties order by original slot: below lim counts as earlier
    assign less  = (entry.mag < ctrl.key.mag) ||
                   ((entry.mag == ctrl.key.mag) && (CW'(CELL) < lim));
    assign lt    = below && less;
    assign ge    = below && (ctrl.key.mag <= entry.mag);
    assign upper = ge && !left_ge;

    always_ff @(posedge clk)
    begin
        case (ctrl.mode)
            plgc_pkg::CELL_REMOVE:
            begin
                if (CW'(CELL) >= lim)
                begin
                    row_mem[tab] <= right_entry;
                end
            end
            plgc_pkg::CELL_INSERT:
            begin
                if (!lt)
                begin
                    row_mem[tab] <= left_lt ? ctrl.key : left_entry;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[rtl/core/plgc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plgc_div
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// ----------------------------------------------------------------------------
module plgc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [plgc_pkg::NUM_W-1:0]  dividend,
    input  logic [plgc_pkg::MAG_W-1:0]  divisor,
    output logic [plgc_pkg::QUO_W-1:0]  quotient,
    output logic                        done
);

    localparam int SW = $clog2(plgc_pkg::QUO_W + 1);

    logic [plgc_pkg::MAG_W-1:0] rem_reg, rem_next;
    logic [plgc_pkg::QUO_W-1:0] low_reg, low_next;
    logic [SW-1:0]              step_reg, step_next;
    logic                       done_reg, done_next;
    logic [plgc_pkg::MAG_W-1:0] trial;

    assign trial    = {rem_reg[plgc_pkg::MAG_W-2:0], low_reg[plgc_pkg::QUO_W-1]};
    assign quotient = low_reg;
    assign done     = done_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (start)
        begin
            // quotient fits QUO_W bits, so the upper numerator part is below divisor
            rem_next  = plgc_pkg::MAG_W'(dividend[plgc_pkg::NUM_W-1:plgc_pkg::QUO_W]);
            low_next  = dividend[plgc_pkg::QUO_W-1:0];
            step_next = SW'(plgc_pkg::QUO_W);
        end
        else if (step_reg != '0)
        begin
            if (trial >= divisor)
            begin
                rem_next = trial - divisor;
                low_next = {low_reg[plgc_pkg::QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                low_next = {low_reg[plgc_pkg::QUO_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            done_next = (step_reg == SW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
    end

endmodule

[rtl/core/piecewise_linear_gain_calibration_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_gain_calibration_core
// Offset and piecewise-linear gain correction over six sorted calibration
// tables held in a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  in        sink       in_valid / in_ready   op sensor axis sample factor
//  out       source     out_valid / out_ready corrected points_used
//  cfg       sink       cfg_we                cfg_index cfg_data
//
//  one item at a time; clear, no-op and empty-table apply go from prep to done,
//  insert adds an insert step (after a remove step with a full table), and apply
//  with points runs lookup, multiply, the 25-step divider, multiply and round.
//  a finished beat waits in the output register while the next item is taken.
//  reset empties all tables and zeroes the offsets; no clearing pass.
// ----------------------------------------------------------------------------
module piecewise_linear_gain_calibration_core #(
    parameter int POINTS  = 8,
    parameter int SENSORS = 2
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             op,
    input  logic                                   sensor,
    input  logic [1:0]                             axis,
    input  logic signed [plgc_pkg::SAMPLE_W-1:0]   sample,
    input  logic signed [plgc_pkg::FAC_W-1:0]      factor,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [plgc_pkg::SAMPLE_W-1:0]   corrected,
    output logic [3:0]                             points_used,
    input  logic                                   cfg_we,
    input  logic [plgc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [plgc_pkg::SAMPLE_W-1:0]          cfg_data
);

    localparam int NTAB = 3 * SENSORS;
    localparam int TW   = $clog2(NTAB);
    localparam int CW   = $clog2(POINTS + 1);
    localparam int PW   = $clog2(POINTS);
    localparam int SW   = plgc_pkg::SAMPLE_W;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_PREP   = 10'b0000000010,
        ST_REMOVE = 10'b0000000100,
        ST_INSERT = 10'b0000001000,
        ST_LOOK   = 10'b0000010000,
        ST_MUL1   = 10'b0000100000,
        ST_DIV    = 10'b0001000000,
        ST_MUL2   = 10'b0010000000,
        ST_ROUND  = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [SW-1:0] zero_reg [plgc_pkg::NREG];
    logic [CW-1:0]        cnt_reg  [NTAB];
    logic [PW-1:0]        ptr_reg  [NTAB];
    logic                 out_valid_reg;

    // item registers
    logic [1:0]                           op_reg;
    logic                                 sensor_reg;
    logic [1:0]                           axis_reg;
    logic signed [SW-1:0]                 sample_reg;
    logic signed [plgc_pkg::FAC_W-1:0]    factor_reg;
    logic signed [SW-1:0]                 g_reg;
    logic [plgc_pkg::MAG_W-1:0]           m_reg;
    logic [CW-1:0]                        n_reg;
    logic [PW-1:0]                        p_reg;
    logic                                 full_reg;
    logic signed [plgc_pkg::FAC_W-1:0]    base_reg;
    logic signed [plgc_pkg::FAC_W:0]      df_reg;
    logic [plgc_pkg::MAG_W-2:0]           dm_reg;
    logic [plgc_pkg::MAG_W-1:0]           span_reg;
    logic signed [plgc_pkg::PROD_W-1:0]   prod_reg;
    logic signed [SW-1:0]                 res_corr_reg;
    logic [CW-1:0]                        res_used_reg;
    logic signed [SW-1:0]                 corr_reg;
    logic [3:0]                           used_reg;

    logic                 sn;
    logic [TW-1:0]        ti;
    logic [2:0]           zi;
    logic signed [SW:0]   diff;
    logic signed [SW-1:0] g;
    logic [plgc_pkg::MAG_W-1:0] m;
    logic [CW-1:0]        n_cur;
    logic                 accept;
    logic                 out_free;

    // cell row
    plgc_pkg::cell_ctrl_t ctrl;
    logic [CW-1:0]        nval;
    logic [CW-1:0]        lim;
    plgc_pkg::entry_t     entries [POINTS];
    logic [POINTS-1:0]    lt_v, ge_v, up_v;
    plgc_pkg::entry_t     hi_e, lo_e, last_e;
    logic [PW-1:0]        last_idx;
    logic                 any_up;

    // arithmetic
    logic [plgc_pkg::FAC_W:0]   adf;
    logic [plgc_pkg::NUM_W-1:0] num;
    logic [plgc_pkg::QUO_W-1:0] quo;
    logic                       div_done;
    logic signed [plgc_pkg::GAIN_W-1:0] fq;
    logic signed [plgc_pkg::GAIN_W-1:0] gain;
    logic signed [plgc_pkg::PROD_W-1:0] prod;
    logic                       pneg;
    logic [plgc_pkg::PROD_W-1:0] pmag;
    logic [plgc_pkg::PROD_W-1:0] pround;
    logic signed [SW-1:0]       rounded;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign corrected = corr_reg;
    assign points_used = used_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign sn = (SENSORS == 1) ? 1'b0 : sensor_reg;
    assign ti = (axis_reg == plgc_pkg::AXIS_NONE) ? '0
              : TW'(axis_reg) * TW'(SENSORS) + TW'(sn);
    assign zi = (axis_reg == plgc_pkg::AXIS_NONE) ? '0
              : 3'(axis_reg) * 3'd2 + 3'(sn);

    // offset removal with saturation
    always_comb
    begin
        diff = {sample_reg[SW-1], sample_reg} - {zero_reg[zi][SW-1], zero_reg[zi]};
        if (diff[SW] != diff[SW-1])
        begin
            g = diff[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
        else
        begin
            g = diff[SW-1:0];
        end
        if (g == {1'b1, {(SW-1){1'b0}}})
        begin
            m = {1'b0, {(SW-1){1'b1}}};
        end
        else
        begin
            m = g[SW-1] ? plgc_pkg::MAG_W'(-g) : plgc_pkg::MAG_W'(g);
        end
        n_cur = cnt_reg[ti];
    end

    // cell control
    always_comb
    begin
        ctrl.key.mag = m_reg;
        ctrl.key.fac = factor_reg;
        if (state_reg == ST_REMOVE)
        begin
            ctrl.mode = plgc_pkg::CELL_REMOVE;
        end
        else if (state_reg == ST_INSERT)
        begin
            ctrl.mode = plgc_pkg::CELL_INSERT;
        end
        else
        begin
            ctrl.mode = plgc_pkg::CELL_HOLD;
        end
        nval = full_reg ? CW'(POINTS - 1) : n_reg;
        lim  = full_reg ? CW'(p_reg) : CW'(POINTS);
    end

    for (genvar k = 0; k < POINTS; k++)
    begin : g_cell
        plgc_cell #(
            .CELL   (k),
            .NTAB   (NTAB),
            .POINTS (POINTS)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .tab         (ti),
            .nval        (nval),
            .lim         (lim),
            .left_entry  ((k == 0) ? ctrl.key : entries[(k == 0) ? 0 : k - 1]),
            .right_entry (entries[(k == POINTS - 1) ? k : k + 1]),
            .left_lt     ((k == 0) ? 1'b1 : lt_v[(k == 0) ? 0 : k - 1]),
            .left_ge     ((k == 0) ? 1'b0 : ge_v[(k == 0) ? 0 : k - 1]),
            .entry       (entries[k]),
            .lt          (lt_v[k]),
            .ge          (ge_v[k]),
            .upper       (up_v[k])
        );
    end

    // bracket selection from the cell flags
    always_comb
    begin
        hi_e = '0;
        lo_e = '0;
        for (int k = 0; k < POINTS; k++)
        begin
            if (up_v[k])
            begin
                hi_e = entries[k];
            end
            if (k > 0 && up_v[k])
            begin
                lo_e = entries[(k > 0) ? k - 1 : 0];
            end
        end
        any_up   = |up_v;
        last_idx = PW'(n_reg - 1'b1);
        last_e   = entries[last_idx];
    end

    // interpolation numerator and gain product
    assign adf  = df_reg[plgc_pkg::FAC_W] ? (plgc_pkg::FAC_W + 1)'(-df_reg)
                                          : (plgc_pkg::FAC_W + 1)'(df_reg);
    assign num  = dm_reg * adf;
    assign fq   = df_reg[plgc_pkg::FAC_W] ? -plgc_pkg::GAIN_W'({1'b0, quo})
                                          : plgc_pkg::GAIN_W'({1'b0, quo});
    assign gain = plgc_pkg::GAIN_W'(base_reg) + fq + plgc_pkg::GAIN_W'(plgc_pkg::GAIN_ONE);
    assign prod = plgc_pkg::PROD_W'(g_reg) * plgc_pkg::PROD_W'(gain);

    plgc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_MUL1),
        .dividend (num),
        .divisor  (span_reg),
        .quotient (quo),
        .done     (div_done)
    );

    // round half away from zero, then saturate
    always_comb
    begin
        pneg   = prod_reg[plgc_pkg::PROD_W-1];
        pmag   = pneg ? plgc_pkg::PROD_W'(-prod_reg) : plgc_pkg::PROD_W'(prod_reg);
        pround = (pmag + plgc_pkg::PROD_W'(plgc_pkg::ROUND_HALF)) >> 16;
        if (pround >= plgc_pkg::PROD_W'({1'b1, {(SW-1){1'b0}}}))
        begin
            rounded = pneg ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end
        else
        begin
            rounded = pneg ? -SW'(pround) : SW'(pround);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_PREP;
            ST_PREP:
            begin
                if (op_reg == plgc_pkg::OP_CLEAR || axis_reg == plgc_pkg::AXIS_NONE)
                begin
                    state_next = ST_DONE;
                end
                else if (op_reg == plgc_pkg::OP_APPLY)
                begin
                    state_next = (n_cur == '0) ? ST_DONE : ST_LOOK;
                end
                else if (op_reg == plgc_pkg::OP_INSERT)
                begin
                    state_next = (n_cur == CW'(POINTS)) ? ST_REMOVE : ST_INSERT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_REMOVE: state_next = ST_INSERT;
            ST_INSERT: state_next = ST_DONE;
            ST_LOOK:   state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_DIV;
            ST_DIV:    if (div_done) state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_ROUND;
            ST_ROUND:  state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < plgc_pkg::NREG; i++)
            begin
                zero_reg[i] <= '0;
            end
            for (int t = 0; t < NTAB; t++)
            begin
                cnt_reg[t] <= '0;
                ptr_reg[t] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we && cfg_index < plgc_pkg::CFG_IDX_W'(plgc_pkg::NREG))
            begin
                zero_reg[cfg_index] <= cfg_data;
            end
            if (state_reg == ST_PREP && op_reg == plgc_pkg::OP_CLEAR)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    cnt_reg[TW'(a * SENSORS) + TW'(sn)] <= '0;
                    ptr_reg[TW'(a * SENSORS) + TW'(sn)] <= '0;
                end
            end
            if (state_reg == ST_INSERT)
            begin
                if (full_reg)
                begin
                    ptr_reg[ti] <= (p_reg == PW'(POINTS - 1)) ? '0 : p_reg + 1'b1;
                end
                else
                begin
                    cnt_reg[ti] <= n_reg + 1'b1;
                end
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op;
            sensor_reg <= sensor;
            axis_reg   <= axis;
            sample_reg <= sample;
            factor_reg <= factor;
        end
        case (state_reg)
            ST_PREP:
            begin
                g_reg    <= g;
                m_reg    <= m;
                n_reg    <= n_cur;
                p_reg    <= ptr_reg[ti];
                full_reg <= (op_reg == plgc_pkg::OP_INSERT) && (n_cur == CW'(POINTS));
                if (op_reg == plgc_pkg::OP_CLEAR || axis_reg == plgc_pkg::AXIS_NONE)
                begin
                    res_used_reg <= '0;
                    res_corr_reg <= '0;
                end
                else
                begin
                    res_used_reg <= n_cur;
                    res_corr_reg <= (op_reg == plgc_pkg::OP_APPLY) ? g : '0;
                end
            end
            ST_INSERT:
            begin
                res_corr_reg <= '0;
                res_used_reg <= full_reg ? n_reg : n_reg + 1'b1;
            end
            ST_LOOK:
            begin
                if (ge_v[0] || !any_up || (m_reg >= last_e.mag))
                begin
                    // clamped at a table end
                    base_reg <= ge_v[0] ? entries[0].fac : last_e.fac;
                    df_reg   <= '0;
                    dm_reg   <= '0;
                    span_reg <= plgc_pkg::MAG_W'(1);
                end
                else
                begin
                    base_reg <= lo_e.fac;
                    df_reg   <= (plgc_pkg::FAC_W + 1)'(hi_e.fac) - (plgc_pkg::FAC_W + 1)'(lo_e.fac);
                    dm_reg   <= (plgc_pkg::MAG_W - 1)'(m_reg - lo_e.mag);
                    span_reg <= hi_e.mag - lo_e.mag;
                end
            end
            ST_MUL2:
            begin
                prod_reg <= prod;
            end
            ST_ROUND:
            begin
                res_corr_reg <= rounded;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    corr_reg <= res_corr_reg;
                    used_reg <= 4'(res_used_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[rtl/core/plgc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plgc_checker
// Port-level checks of the calibration core, bound to the top level.
// ----------------------------------------------------------------------------
module plgc_checker #(
    parameter int POINTS = 8
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] corrected,
    input logic [3:0]  points_used
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(corrected) && $stable(points_used))
        else $error("output beat changed while stalled");

    // one item in flight: no input beat right after one is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // a new result only comes from work that held the input side
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without an item in work");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (POINTS >= 16) || (points_used <= 4'(POINTS)))
        else $error("fill count above table size");

endmodule

bind piecewise_linear_gain_calibration_core plgc_checker #(.POINTS(POINTS)) u_plgc_checker (.*);
